FILE: rtl/core/fixed_prefix_code_codec_macros.svh
// ----------------------------------------------------------------------------
// Fixed prefix-code codec assertion macros
// Shared concurrent assertion forms for the codec checkers.
// ----------------------------------------------------------------------------
`ifndef FIXED_PREFIX_CODE_CODEC_MACROS_SVH
`define FIXED_PREFIX_CODE_CODEC_MACROS_SVH

// same-cycle implication
`define FPCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FPCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/fpcc_pkg.sv
// ----------------------------------------------------------------------------
// Fixed prefix-code codec package
// Code table and lookup functions shared by the codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpcc_pkg;

   localparam int NUM_CODES = 14;

   typedef struct packed {
      logic [7:0] sym;
      logic [5:0] code;
      logic [2:0] len;
   } code_entry_type;

   // encoder view: code left aligned in a byte, length 4..8
   typedef struct packed {
      logic [7:0] code;
      logic [3:0] len;
   } enc_code_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] sym;
   } dec_match_type;

   localparam code_entry_type CODE_TABLE [NUM_CODES] = '{
      '{sym: 8'd32,  code: 6'b001011, len: 3'd4},
      '{sym: 8'd101, code: 6'b001101, len: 3'd4},
      '{sym: 8'd116, code: 6'b011110, len: 3'd5},
      '{sym: 8'd111, code: 6'b011101, len: 3'd5},
      '{sym: 8'd97,  code: 6'b010011, len: 3'd5},
      '{sym: 8'd104, code: 6'b011001, len: 3'd5},
      '{sym: 8'd110, code: 6'b010001, len: 3'd5},
      '{sym: 8'd115, code: 6'b011100, len: 3'd5},
      '{sym: 8'd105, code: 6'b011000, len: 3'd5},
      '{sym: 8'd114, code: 6'b100001, len: 3'd6},
      '{sym: 8'd100, code: 6'b010010, len: 3'd5},
      '{sym: 8'd108, code: 6'b011111, len: 3'd5},
      '{sym: 8'd117, code: 6'b100000, len: 3'd6},
      '{sym: 8'd109, code: 6'b001010, len: 3'd4}
   };

   // table symbol -> short code, anything else -> 8-bit literal
   function automatic enc_code_type enc_lookup(input logic [7:0] sym);
      enc_code_type res;
      logic [7:0]   wide;
      res.code = sym;
      res.len  = 4'd8;
      for (int i = 0; i < NUM_CODES; i++) begin
         if (CODE_TABLE[i].sym == sym) begin
            wide     = {2'b00, CODE_TABLE[i].code};
            res.code = wide << (4'd8 - {1'b0, CODE_TABLE[i].len});
            res.len  = {1'b0, CODE_TABLE[i].len};
         end
      end
      return res;
   endfunction

   // right-aligned pending bits of a given count against the table
   function automatic dec_match_type dec_lookup(input logic [7:0] bits,
                                               input logic [2:0] count);
      dec_match_type res;
      res.hit = 1'b0;
      res.sym = 8'd0;
      for (int i = 0; i < NUM_CODES; i++) begin
         if (CODE_TABLE[i].len == count && {2'b00, CODE_TABLE[i].code} == bits) begin
            res.hit = 1'b1;
            res.sym = CODE_TABLE[i].sym;
         end
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/fpcc_if.sv
// ----------------------------------------------------------------------------
// Fixed prefix-code codec channels
// Valid/ready channel interfaces for input items, results and the mode CSR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fpcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       flush;

   modport source (output valid, output data_byte, output flush, input ready);
   modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

interface fpcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface fpcc_csr_if;
   logic valid;
   logic ready;
   logic codec_mode;

   modport source (output valid, output codec_mode, input ready);
   modport sink   (input valid, input codec_mode, output ready);
endinterface

FILE: rtl/core/fixed_prefix_code_codec.sv
// ----------------------------------------------------------------------------
// Fixed prefix-code codec
// Bit-serial static prefix-code encoder/decoder for byte streams.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one byte (data_byte) or an end-of-stream marker (flush).
//  - rsp_if returns packed code bytes (encode) or decoded characters
//    (decode); last marks the final result caused by one input transfer.
//    An input gives zero, one or two results.
//  - csr_if writes codec_mode (0 encode, 1 decode); always ready, only to be
//    written while the codec is idle. Pending bits carry across a change.
//  - One bit per cycle while no second result waits for the held slot: ready
//    stays low while the code bits (encode), the eight bits (decode) or the
//    pad bits, if any (flush), are shifted and the held result drains; one item at a time.
//  - An earlier result shows in the cycle after the step that completes the next
//    one; the final one in the cycle after the drain state passes it on.
//  - Reset clears mode (encode), the accumulator and the bit count.
//  - A stalled receiver holds the output register; the shifter stalls only
//    when a second result would need the held slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_prefix_code_codec
   import fpcc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   fpcc_req_if.sink     req_if,
   fpcc_rsp_if.source   rsp_if,
   fpcc_csr_if.sink     csr_if
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic          mode_ff, mode_in;
   logic [7:0]    acc_ff, acc_in;       // pending bits, right aligned
   logic [2:0]    cnt_ff, cnt_in;       // number of pending bits
   logic [7:0]    shreg_ff, shreg_in;   // code bits still to feed, MSB first
   logic [3:0]    left_ff, left_in;     // bits still to feed
   logic [1:0]    nres_ff, nres_in;     // results raised by this item
   logic [7:0]    hold_ff, hold_in;     // newest result, waiting to learn last
   logic          hold_vld_ff, hold_vld_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_xfer;
   logic          out_free;
   logic [7:0]    acc_sh;
   logic [3:0]    cnt_sh;
   logic          full;
   dec_match_type dec;
   enc_code_type  enc;
   logic          res_now;
   logic [7:0]    res_val;
   logic          emit;
   logic          step;
   logic          push_mid;
   logic          push_end;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid    = rsp_vld_ff;
   assign rsp_if.out_byte = rsp_byte_ff;
   assign rsp_if.last     = rsp_last_ff;

   assign req_xfer = req_if.valid & req_if.ready;
   assign out_free = ~rsp_vld_ff | rsp_if.ready;

   // one bit step
   assign acc_sh  = {acc_ff[6:0], shreg_ff[7]};
   assign cnt_sh  = {1'b0, cnt_ff} + 4'd1;
   assign full    = cnt_sh[3];
   assign dec     = dec_lookup(acc_sh, cnt_sh[2:0]);
   assign enc     = enc_lookup(req_if.data_byte);
   assign res_now = full | (mode_ff & dec.hit);
   assign res_val = full ? acc_sh : dec.sym;
   // beyond two results per item nothing is reported
   assign emit    = res_now & (nres_ff != 2'd2);
   // a second result must first move the held one out
   assign step    = (state_ff == ST_SHIFT) & ~(emit & hold_vld_ff & ~out_free);
   assign push_mid = step & emit & hold_vld_ff;
   assign push_end = (state_ff == ST_DRAIN) & hold_vld_ff & out_free;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      shreg_in    = shreg_ff;
      left_in     = left_ff;
      nres_in     = nres_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;

      if (csr_if.valid & csr_if.ready) begin
         mode_in = csr_if.codec_mode;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               nres_in = 2'd0;
               if (req_if.flush) begin
                  if (~mode_ff && cnt_ff != 3'd0) begin
                     // pad with zero bits up to a full byte
                     shreg_in = 8'd0;
                     left_in  = 4'd8 - {1'b0, cnt_ff};
                     state_in = ST_SHIFT;
                  end else begin
                     acc_in   = 8'd0;
                     cnt_in   = 3'd0;
                     state_in = ST_DRAIN;
                  end
               end else if (~mode_ff) begin
                  shreg_in = enc.code;
                  left_in  = enc.len;
                  state_in = ST_SHIFT;
               end else begin
                  shreg_in = req_if.data_byte;
                  left_in  = 4'd8;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (step) begin
               shreg_in = {shreg_ff[6:0], 1'b0};
               left_in  = left_ff - 4'd1;
               if (res_now) begin
                  acc_in = 8'd0;
                  cnt_in = 3'd0;
               end else begin
                  acc_in = acc_sh;
                  cnt_in = cnt_sh[2:0];
               end
               if (emit) begin
                  hold_in     = res_val;
                  hold_vld_in = 1'b1;
                  nres_in     = nres_ff + 2'd1;
               end
               if (left_ff == 4'd1) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (~hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               hold_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: earlier result goes out with last low, final with last high
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if (push_mid | push_end) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = hold_ff;
         rsp_last_in = push_end;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= 1'b0;
         acc_ff      <= 8'd0;
         cnt_ff      <= 3'd0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff    <= shreg_in;
      left_ff     <= left_in;
      nres_ff     <= nres_in;
      hold_ff     <= hold_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

FILE: rtl/core/fpcc_checker.sv
// ----------------------------------------------------------------------------
// Fixed prefix-code codec checker
// Port-level assertions, bound to the codec top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_prefix_code_codec_macros.svh"

module fpcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       csr_ready
);

   `FPCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last), "stalled result changed")

   `FPCC_ASSERT_NOW(a_busy_mid_item, clock, reset, rsp_valid && !rsp_last, !req_ready, "new item taken before final result of previous one")

   `FPCC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "back-to-back transfer on a sequential engine")

   `FPCC_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready, "mode register not ready")

endmodule

bind fixed_prefix_code_codec fpcc_checker u_fpcc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_out_byte (rsp_if.out_byte),
   .rsp_last     (rsp_if.last),
   .csr_ready    (csr_if.ready)
);

FILE: dv/tb_fixed_prefix_code_codec.sv
// ----------------------------------------------------------------------------
// Fixed prefix-code codec testbench
// Drives byte and flush transfers through both codec modes, predicts output
// bytes with an independent bit-level model of the code or takes typed-in
// ones, and checks the results in order, with and without random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_prefix_code_codec;

   // codec_mode values
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam int RANDOM_ITEMS    = 1400;
   localparam int SETTLE_CYCLES   = 16;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int RUN_LIMIT_NS    = 5_000_000;

   typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_type;

   // one expected output transfer
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } codec_result_type;

   // directed stimulus row; r0/r1 only used when the result is typed in
   typedef struct packed {
      row_kind_type kind;
      logic         mode;
      logic [7:0]   data;
      logic         flush;
      logic         typed;
      logic [1:0]   n;
      logic [7:0]   r0;
      logic [7:0]   r1;
   } dir_row_type;

   localparam int N_DIRECTED = 25;

   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      // encode straight after reset: space then 'e' fill one byte exactly
      '{ROW_ITEM, MODE_ENCODE, 8'h20, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'h65, 1'b0, 1'b1, 2'd1, 8'hBD, 8'h00},
      // flush with nothing pending gives nothing
      '{ROW_ITEM, MODE_ENCODE, 8'h5A, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
      // byte extremes go out as literals
      '{ROW_ITEM, MODE_ENCODE, 8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00},
      // 'm' then flush: zero padded on the right
      '{ROW_ITEM, MODE_ENCODE, 8'h6D, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'h00, 1'b1, 1'b1, 2'd1, 8'hA0, 8'h00},
      // six-bit codes, head-1 literal with bits pending
      '{ROW_ITEM, MODE_ENCODE, 8'h72, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'h75, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'h80, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'h74, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'hC3, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
      // leave four code bits pending, then switch to decode over them
      '{ROW_ITEM, MODE_ENCODE, 8'h20, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_MODE, MODE_DECODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_DECODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      // decode flush drops partial bits silently
      '{ROW_ITEM, MODE_DECODE, 8'hFF, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
      // two characters out of one byte
      '{ROW_ITEM, MODE_DECODE, 8'hBD, 1'b0, 1'b1, 2'd2, 8'h20, 8'h65},
      '{ROW_ITEM, MODE_DECODE, 8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_DECODE, 8'hFF, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_DECODE, 8'h55, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_DECODE, 8'h00, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_DECODE, 8'h84, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_DECODE, 8'h3C, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
      '{ROW_MODE, MODE_ENCODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_ITEM, MODE_ENCODE, 8'h7F, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00}
   };

   logic clock = 1'b0;
   logic reset;

   fpcc_req_if req_if ();
   fpcc_rsp_if rsp_if ();
   fpcc_csr_if csr_if ();

   fixed_prefix_code_codec uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state: mode register plus the right-aligned pending bits
   logic       cur_mode;
   logic [7:0] pend_bits;
   logic [3:0] pend_count;

   codec_result_type due_results [$];

   int mismatches    = 0;
   int items_sent    = 0;
   int send_idle_pct = 11;
   int rsp_stall_pct = 56;
   bit rsp_hold_req  = 1'b0;
   bit hold_done     = 1'b0;
   bit pause_done    = 1'b0;
   int hold_mark     = 32'h7FFF_FFFF;
   int pause_mark    = 32'h7FFF_FFFF;

   // table symbol -> left-unaligned code and length; others are 8-bit literals
   function automatic void code_for_symbol(input logic [7:0] sym,
                                           output logic [7:0] code, output int len);
      len = 5;
      case (sym)
         8'd32:   begin code = 8'h0B; len = 4; end
         8'd101:  begin code = 8'h0D; len = 4; end
         8'd109:  begin code = 8'h0A; len = 4; end
         8'd116:  code = 8'h1E;
         8'd111:  code = 8'h1D;
         8'd97:   code = 8'h13;
         8'd104:  code = 8'h19;
         8'd110:  code = 8'h11;
         8'd115:  code = 8'h1C;
         8'd105:  code = 8'h18;
         8'd100:  code = 8'h12;
         8'd108:  code = 8'h1F;
         8'd114:  begin code = 8'h21; len = 6; end
         8'd117:  begin code = 8'h20; len = 6; end
         default: begin code = sym;   len = 8; end
      endcase
   endfunction

   // pending bits of a given count that form a complete code
   function automatic bit symbol_for_code(input logic [7:0] bits, input logic [3:0] count,
                                          output logic [7:0] sym);
      symbol_for_code = 1'b1;
      sym = 8'h00;
      case ({count, bits})
         {4'd4, 8'h0B}: sym = 8'd32;
         {4'd4, 8'h0D}: sym = 8'd101;
         {4'd4, 8'h0A}: sym = 8'd109;
         {4'd5, 8'h1E}: sym = 8'd116;
         {4'd5, 8'h1D}: sym = 8'd111;
         {4'd5, 8'h13}: sym = 8'd97;
         {4'd5, 8'h19}: sym = 8'd104;
         {4'd5, 8'h11}: sym = 8'd110;
         {4'd5, 8'h1C}: sym = 8'd115;
         {4'd5, 8'h18}: sym = 8'd105;
         {4'd5, 8'h12}: sym = 8'd100;
         {4'd5, 8'h1F}: sym = 8'd108;
         {4'd6, 8'h21}: sym = 8'd114;
         {4'd6, 8'h20}: sym = 8'd117;
         default:       symbol_for_code = 1'b0;
      endcase
   endfunction

   // One input item through the codec. Returns the number of output bytes,
   // first in outs[7:0], second in outs[15:8]. Also used to build
   // well-formed code streams for the decode phases.
   function automatic int codec_predict(input logic mode, inout logic [7:0] acc,
                                        inout logic [3:0] cnt, input logic [7:0] data,
                                        input logic flush, output logic [15:0] outs);
      int         n;
      int         len;
      logic [7:0] code;
      logic [7:0] sym;
      n = 0;
      outs = '0;
      if (cnt > 4'd7) begin
         cnt = 4'd0;
         acc = 8'h00;
      end
      if (flush) begin
         if (mode == MODE_ENCODE && cnt != 4'd0) begin
            code = acc << (4'd8 - cnt);
            outs[7:0] = code;
            n = 1;
         end
         acc = 8'h00;
         cnt = 4'd0;
      end else if (mode == MODE_ENCODE) begin
         code_for_symbol(data, code, len);
         for (int i = len; i > 0; i--) begin
            acc = {acc[6:0], code[i-1]};
            cnt = cnt + 4'd1;
            if (cnt == 4'd8) begin
               outs[n*8 +: 8] = acc;
               n++;
               acc = 8'h00;
               cnt = 4'd0;
            end
         end
      end else begin
         for (int i = 8; i > 0; i--) begin
            acc = {acc[6:0], data[i-1]};
            cnt = cnt + 4'd1;
            if (cnt == 4'd8) begin
               // eight bits with no match: literal, head bit either way
               outs[n*8 +: 8] = acc;
               n++;
               acc = 8'h00;
               cnt = 4'd0;
            end else if (symbol_for_code(acc, cnt, sym)) begin
               outs[n*8 +: 8] = sym;
               n++;
               acc = 8'h00;
               cnt = 4'd0;
            end
         end
      end
      return n;
   endfunction

   // mostly table symbols, some 7-bit literals, a few head-1 literals
   function automatic logic [7:0] message_char();
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         case ($urandom_range(13))
            0:  return 8'd32;
            1:  return 8'd101;
            2:  return 8'd116;
            3:  return 8'd111;
            4:  return 8'd97;
            5:  return 8'd104;
            6:  return 8'd110;
            7:  return 8'd115;
            8:  return 8'd105;
            9:  return 8'd114;
            10: return 8'd100;
            11: return 8'd108;
            12: return 8'd117;
            default: return 8'd109;
         endcase
      end else if (r < 96) begin
         return 8'($urandom_range(127));
      end
      return 8'($urandom_range(128, 255));
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // Offer one transfer, idling first at the current rate. Returns at the
   // edge that accepts it with valid still high, so a following call can
   // keep valid up without a low/high pair in one step.
   task automatic send_item(input logic [7:0] data, input logic flush);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.flush     <= flush;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // sender pause: nothing offered until every expected result is back,
   // then a settling wait for an item that produced nothing
   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic issue_item(input logic [7:0] data, input logic flush);
      logic [15:0] outs;
      int          n;
      if (!hold_done && items_sent >= hold_mark) begin
         rsp_hold_req = 1'b1;
         hold_done    = 1'b1;
      end
      if (!pause_done && items_sent >= pause_mark) begin
         wait_results_drained();
         pause_done = 1'b1;
      end
      n = codec_predict(cur_mode, pend_bits, pend_count, data, flush, outs);
      for (int i = 0; i < n; i++)
         due_results.push_back('{out_byte: outs[i*8 +: 8], last: (i == n - 1)});
      send_item(data, flush);
   endtask

   // mode changes only with the codec idle; pending bits stay put
   task automatic write_mode(input logic mode);
      wait_results_drained();
      csr_if.valid      <= 1'b1;
      csr_if.codec_mode <= mode;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      cur_mode = mode;
   endtask

   // --------------------------------------------------------------------
   // Result side: check each transfer against the oldest expectation,
   // then pick ready for the next cycle. A long hold is counted here.
   // --------------------------------------------------------------------
   initial begin
      int               hold_left;
      codec_result_type want;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else begin
            if (rsp_if.valid && rsp_if.ready) begin
               if (due_results.size() == 0) begin
                  report_mismatch($sformatf("unexpected result out_byte=%02h last=%b",
                                            rsp_if.out_byte, rsp_if.last));
               end else begin
                  want = due_results.pop_front();
                  if (rsp_if.out_byte !== want.out_byte)
                     report_mismatch($sformatf("out_byte %02h, expected %02h",
                                               rsp_if.out_byte, want.out_byte));
                  if (rsp_if.last !== want.last)
                     report_mismatch($sformatf("last %b, expected %b (out_byte %02h)",
                                               rsp_if.last, want.last, want.out_byte));
               end
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_if.ready <= 1'b0;
            end else if (rsp_hold_req) begin
               // receiver backs off while the sender keeps offering
               rsp_hold_req = 1'b0;
               hold_left    = RSP_HOLD_CYCLES;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Stimulus: directed table first, then random phases
   // --------------------------------------------------------------------
   initial begin
      logic [15:0] outs;
      logic [7:0]  gen_acc;
      logic [3:0]  gen_cnt;
      logic [7:0]  b;
      logic        next_mode;
      int          n;
      int          rand_start;
      int          phase_start;
      int          phase_len;
      int          msg_len;
      int          r;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.data_byte  <= 8'h00;
      req_if.flush      <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.codec_mode <= MODE_ENCODE;
      cur_mode   = MODE_ENCODE;
      pend_bits  = 8'h00;
      pend_count = 4'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; typed rows carry their result, the rest are predicted
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED[i].kind == ROW_MODE) begin
            write_mode(DIRECTED[i].mode);
         end else if (DIRECTED[i].typed) begin
            n = codec_predict(cur_mode, pend_bits, pend_count, DIRECTED[i].data,
                              DIRECTED[i].flush, outs);
            for (int j = 0; j < int'(DIRECTED[i].n); j++)
               due_results.push_back('{out_byte: (j == 0) ? DIRECTED[i].r0 : DIRECTED[i].r1,
                                       last: (j == int'(DIRECTED[i].n) - 1)});
            send_item(DIRECTED[i].data, DIRECTED[i].flush);
         end else begin
            issue_item(DIRECTED[i].data, DIRECTED[i].flush);
         end
      end

      rand_start = items_sent;
      hold_mark  = rand_start + 500;
      pause_mark = rand_start + 900;

      while (items_sent - rand_start < RANDOM_ITEMS) begin
         // idling regimes: sender light / receiver heavy, swapped, then none
         if (items_sent - rand_start < RANDOM_ITEMS / 3) begin
            send_idle_pct = 11;
            rsp_stall_pct = 56;
         end else if (items_sent - rand_start < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 56;
            rsp_stall_pct = 11;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end

         next_mode = ($urandom_range(3) == 0) ? cur_mode : ~cur_mode;
         write_mode(next_mode);
         phase_start = items_sent;
         phase_len   = $urandom_range(15, 50);

         if (cur_mode == MODE_ENCODE) begin
            while (items_sent - phase_start < phase_len) begin
               r = $urandom_range(99);
               if (r < 65)
                  issue_item(message_char(), 1'b0);
               else if (r < 93)
                  issue_item(8'($urandom_range(255)), 1'b0);
               else
                  issue_item(8'($urandom_range(255)), 1'b1);
            end
            // leave bits pending across the mode change about half the time
            if ($urandom_range(1) == 0)
               issue_item(8'($urandom_range(255)), 1'b1);
         end else begin
            while (items_sent - phase_start < phase_len) begin
               if ($urandom_range(99) < 80) begin
                  // well-formed stream: align, packed message, pad byte, mostly a flush
                  issue_item(8'($urandom_range(255)), 1'b1);
                  gen_acc = 8'h00;
                  gen_cnt = 4'd0;
                  msg_len = $urandom_range(1, 12);
                  for (int m = 0; m < msg_len; m++) begin
                     n = codec_predict(MODE_ENCODE, gen_acc, gen_cnt, message_char(),
                                       1'b0, outs);
                     for (int j = 0; j < n; j++) begin
                        b = outs[j*8 +: 8];
                        // occasional bit error breaks the stream
                        if ($urandom_range(29) == 0)
                           b[$urandom_range(7)] = ~b[$urandom_range(7)];
                        issue_item(b, 1'b0);
                     end
                  end
                  n = codec_predict(MODE_ENCODE, gen_acc, gen_cnt, 8'h00, 1'b1, outs);
                  if (n > 0)
                     issue_item(outs[7:0], 1'b0);
                  if ($urandom_range(4) != 0)
                     issue_item(8'($urandom_range(255)), 1'b1);
               end else begin
                  issue_item(8'($urandom_range(255)), 1'b0);
               end
            end
         end
      end

      wait_results_drained();
      if (mismatches == 0)
         $display("tb_fixed_prefix_code_codec: clean");
      else
         $display("tb_fixed_prefix_code_codec: errors");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_fixed_prefix_code_codec: errors");
      $finish;
   end

endmodule
